[rtl/core/idll_pkg.sv]
// ----------------------------------------------------------------------------
// idll_pkg
// Shared types and constants for the indexed doubly linked list manager.
// ----------------------------------------------------------------------------
package idll_pkg;

  localparam int DEF_NODE_COUNT = 256;
  localparam int IDX_W          = 8;
  localparam int CNT_W          = 9;
  localparam int REQ_W          = 3;
  localparam int STAT_W         = 2;

  localparam logic [REQ_W-1:0] REQ_ADD_FRONT    = 3'd0;
  localparam logic [REQ_W-1:0] REQ_ADD_BACK     = 3'd1;
  localparam logic [REQ_W-1:0] REQ_REMOVE_NODE  = 3'd2;
  localparam logic [REQ_W-1:0] REQ_REMOVE_FRONT = 3'd3;
  localparam logic [REQ_W-1:0] REQ_SUCCESSOR    = 3'd4;

  localparam logic [STAT_W-1:0] STAT_OK     = 2'd0;
  localparam logic [STAT_W-1:0] STAT_NONE   = 2'd1;
  localparam logic [STAT_W-1:0] STAT_MISUSE = 2'd2;

  typedef struct packed {
    logic [REQ_W-1:0] req_type;
    logic [IDX_W-1:0] node_index;
  } req_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic              result_valid;
    logic [IDX_W-1:0]  result_index;
    logic [IDX_W-1:0]  list_first;
    logic [IDX_W-1:0]  list_last;
    logic [CNT_W-1:0]  list_count;
  } rsp_t;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  typedef struct packed {
    logic load;
    logic exec;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } sts_t;

endpackage

[rtl/core/idll_ram.sv]
// ----------------------------------------------------------------------------
// idll_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module idll_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/core/idll_ctrl.sv]
// ----------------------------------------------------------------------------
// idll_ctrl
// Request sequencer: load (link read) then execute (link write, result).
// ----------------------------------------------------------------------------
module idll_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  idll_pkg::sts_t sts,
  output idll_pkg::cmd_t cmd
);

  import idll_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (sts.out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_stall = 1'b1;
    cmd      = '0;
    case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      S_EXEC: begin
        cmd.exec = sts.out_free;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

endmodule

[rtl/core/idll_dp.sv]
// ----------------------------------------------------------------------------
// idll_dp
// List datapath: link memories, membership flags, list head, result register.
// ----------------------------------------------------------------------------
module idll_dp #(
  parameter int NODE_COUNT = idll_pkg::DEF_NODE_COUNT
) (
  input  logic           clk,
  input  logic           rst_n,
  input  idll_pkg::req_t in_data,
  input  idll_pkg::cmd_t cmd,
  output idll_pkg::sts_t sts,
  input  logic           out_stall,
  output logic           out_valid,
  output idll_pkg::rsp_t out_data
);

  import idll_pkg::*;

  localparam int POOL = (NODE_COUNT < (1 << IDX_W)) ? NODE_COUNT : (1 << IDX_W);
  localparam int AW   = $clog2(POOL);
  localparam int PW   = IDX_W + 9;

  logic [REQ_W-1:0] req_r;
  logic [AW-1:0]    addr_r;
  logic             inpool_r;
  logic [AW-1:0]    first_r, first_nxt;
  logic [AW-1:0]    last_r, last_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [(1 << AW)-1:0] member_r;

  logic [AW-1:0] addr_in;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] prev_rd, next_rd;

  logic          prev_we, next_we;
  logic [AW-1:0] prev_wa, next_wa;
  logic [AW-1:0] prev_wd, next_wd;

  logic mem_set, mem_clr;
  logic linked, is_first, is_last, empty;

  rsp_t rsp;
  rsp_t out_r;
  logic out_valid_r;

  assign addr_in = (in_data.req_type == REQ_REMOVE_FRONT) ? first_r
                                                          : AW'(in_data.node_index);
  assign rd_addr = cmd.load ? addr_in : addr_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r    <= in_data.req_type;
      addr_r   <= addr_in;
      inpool_r <= (PW'(in_data.node_index) < PW'(NODE_COUNT));
    end
  end

  idll_ram #(.WIDTH(AW), .DEPTH(POOL)) u_prev_ram (
    .clk   (clk),
    .we    (prev_we),
    .waddr (prev_wa),
    .wdata (prev_wd),
    .raddr (rd_addr),
    .rdata (prev_rd)
  );

  idll_ram #(.WIDTH(AW), .DEPTH(POOL)) u_next_ram (
    .clk   (clk),
    .we    (next_we),
    .waddr (next_wa),
    .wdata (next_wd),
    .raddr (rd_addr),
    .rdata (next_rd)
  );

  assign linked   = inpool_r && member_r[addr_r];
  assign is_first = (addr_r == first_r);
  assign is_last  = (addr_r == last_r);
  assign empty    = (cnt_r == '0);

  always_comb begin
    prev_we   = 1'b0;
    next_we   = 1'b0;
    prev_wa   = addr_r;
    next_wa   = addr_r;
    prev_wd   = addr_r;
    next_wd   = addr_r;
    mem_set   = 1'b0;
    mem_clr   = 1'b0;
    first_nxt = first_r;
    last_nxt  = last_r;
    cnt_nxt   = cnt_r;
    rsp       = '0;
    rsp.status = STAT_OK;

    case (req_r)
      REQ_ADD_FRONT, REQ_ADD_BACK: begin
        if (!inpool_r || linked) begin
          rsp.status = STAT_MISUSE;
        end else begin
          mem_set = 1'b1;
          cnt_nxt = cnt_r + CNT_W'(1);
          if (empty) begin
            first_nxt = addr_r;
            last_nxt  = addr_r;
          end else if (req_r == REQ_ADD_FRONT) begin
            next_we   = 1'b1;
            next_wa   = addr_r;
            next_wd   = first_r;
            prev_we   = 1'b1;
            prev_wa   = first_r;
            prev_wd   = addr_r;
            first_nxt = addr_r;
          end else begin
            prev_we  = 1'b1;
            prev_wa  = addr_r;
            prev_wd  = last_r;
            next_we  = 1'b1;
            next_wa  = last_r;
            next_wd  = addr_r;
            last_nxt = addr_r;
          end
        end
      end
      REQ_REMOVE_NODE, REQ_REMOVE_FRONT: begin
        if (req_r == REQ_REMOVE_NODE && !linked) begin
          rsp.status = STAT_MISUSE;
        end else if (req_r == REQ_REMOVE_FRONT && empty) begin
          rsp.status = STAT_NONE;
        end else begin
          if (req_r == REQ_REMOVE_FRONT) begin
            rsp.result_valid = 1'b1;
            rsp.result_index = IDX_W'(addr_r);
          end
          mem_clr = 1'b1;
          cnt_nxt = cnt_r - CNT_W'(1);
          if (!is_first) begin
            next_we = 1'b1;
            next_wa = prev_rd;
            next_wd = next_rd;
          end
          if (!is_last) begin
            prev_we = 1'b1;
            prev_wa = next_rd;
            prev_wd = prev_rd;
          end
          first_nxt = is_first ? next_rd : first_r;
          last_nxt  = is_last ? prev_rd : last_r;
        end
      end
      REQ_SUCCESSOR: begin
        if (!linked) begin
          rsp.status = STAT_MISUSE;
        end else if (is_last) begin
          rsp.status = STAT_NONE;
        end else begin
          rsp.result_valid = 1'b1;
          rsp.result_index = IDX_W'(next_rd);
        end
      end
      default: rsp.status = STAT_MISUSE;
    endcase

    rsp.list_count = cnt_nxt;
    rsp.list_first = (cnt_nxt != '0) ? IDX_W'(first_nxt) : '0;
    rsp.list_last  = (cnt_nxt != '0) ? IDX_W'(last_nxt) : '0;

    if (!cmd.exec) begin
      prev_we = 1'b0;
      next_we = 1'b0;
      mem_set = 1'b0;
      mem_clr = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      member_r <= '0;
      cnt_r    <= '0;
      first_r  <= '0;
      last_r   <= '0;
    end else if (cmd.exec) begin
      cnt_r   <= cnt_nxt;
      first_r <= first_nxt;
      last_r  <= last_nxt;
      if (mem_set) begin
        member_r[addr_r] <= 1'b1;
      end else if (mem_clr) begin
        member_r[addr_r] <= 1'b0;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.exec) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      out_r <= rsp;
    end
  end

  assign sts.out_free = !out_valid_r || !out_stall;
  assign out_valid    = out_valid_r;
  assign out_data     = out_r;

endmodule

[rtl/core/indexed_doubly_linked_list.sv]
// ----------------------------------------------------------------------------
// indexed_doubly_linked_list
// Single list over a fixed pool of indexed nodes with prev/next link memories.
//
//   Channel | Direction | Handshake          | Payload
//   in      | input     | in_valid/in_stall   | req_t  (req_type, node_index)
//   out     | output    | out_valid/out_stall | rsp_t  (status, index, head)
//
// Each request has a load step and an execute step: the transfer cycle reads
// the node's links from the synchronous link RAMs; execute, once the result
// register is free, writes neighbor links and loads the result register. A
// new transfer is taken the cycle after that. While a result waits under
// out_stall, one more request may be read and then holds in execute. Reset
// clears the membership flags; link RAM contents need no clearing.
// ----------------------------------------------------------------------------
module indexed_doubly_linked_list #(
  parameter int NODE_COUNT = idll_pkg::DEF_NODE_COUNT
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  idll_pkg::req_t in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output idll_pkg::rsp_t out_data
);

  import idll_pkg::*;

  cmd_t cmd;
  sts_t sts;

  idll_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  idll_dp #(.NODE_COUNT(NODE_COUNT)) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  a_busy_after_load: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> in_stall)
    else $error("input not stalled during execute");

  a_exec_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec |=> out_valid)
    else $error("execute did not load result");

  a_result_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.result_valid) |-> (out_data.status == STAT_OK))
    else $error("result index with non-ok status");

  a_empty_head: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.list_count == '0) |->
      (out_data.list_first == '0 && out_data.list_last == '0))
    else $error("empty list reports head nodes");

endmodule
